### rtl/pursuit_steering_angle_macros.svh
// Assertion helpers used by the top-level RTL file
`ifndef PURSUIT_STEERING_ANGLE_MACROS_SVH
`define PURSUIT_STEERING_ANGLE_MACROS_SVH

// assert an implication, reset aware
`define PSA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error(msg);

// assert a next-cycle implication, reset aware
`define PSA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

### rtl/psa_pkg.sv
`default_nettype none
package psa_pkg;
	localparam int AtanEntries = 30;
	localparam logic signed [35:0] PiQ30     = 36'sd3373259426;
	localparam logic signed [35:0] HalfPiQ30 = 36'sd1686629713;
	localparam logic signed [35:0] TwoPiQ30  = 36'sd6746518852;
	localparam logic signed [35:0] InvGainQ30 = 36'sd652032874;

	localparam logic [0:0] RegWheelbase = 1'b0;
	localparam logic [0:0] RegDistComp  = 1'b1;

	function automatic logic signed [35:0] atan_q30(input int i);
		logic signed [35:0] r;
		case (i)
			0: r = 36'sd843314857;
			1: r = 36'sd497837829;
			2: r = 36'sd263043837;
			3: r = 36'sd133525159;
			4: r = 36'sd67021687;
			5: r = 36'sd33543516;
			6: r = 36'sd16775851;
			7: r = 36'sd8388437;
			8: r = 36'sd4194283;
			9: r = 36'sd2097149;
			default: r = (i < AtanEntries) ? (36'sd1 <<< (30 - i)) : 36'sd0;
		endcase
		return r;
	endfunction

	typedef struct packed {
		logic        valid;
		logic        stall;
	} pipe_ctl_t;
endpackage
`default_nettype wire

### rtl/psa_stream_if.sv
`default_nettype none
interface psa_stream_if #(parameter int W = 32);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/psa_sqrt.sv
`default_nettype none
// Pipelined rounding square root, one result bit per stage.
module psa_sqrt
	import psa_pkg::*;
#(
	parameter int TAG_W = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               in_valid,
	input  wire logic [65:0]        in_n,
	input  wire logic [TAG_W-1:0]   in_tag,
	output logic                    out_valid,
	output logic [34:0]             out_root,
	output logic [TAG_W-1:0]        out_tag
);
	localparam int Steps = 34;
	logic [Steps:0]         v_s1;
	logic [66:0]            rem_s1  [Steps+1];
	logic [34:0]            root_s1 [Steps+1];
	logic [TAG_W-1:0]       tag_s1  [Steps+1];

	always_comb begin
		v_s1[0]    = in_valid;
		rem_s1[0]  = {1'b0, in_n};
		root_s1[0] = '0;
		tag_s1[0]  = in_tag;
	end

	// rem holds n - root^2; setting bit B adds (root << (B+1)) + 2^(2B) to the square
	for (genvar k = 0; k < Steps; k++) begin : g_st
		localparam int B = 33 - k;
		logic [68:0] trial;
		logic        take;
		always_comb begin
			trial = (69'(root_s1[k]) << (B + 1)) | (69'd1 << (2 * B));
			take  = 69'(rem_s1[k]) >= trial;
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s1[k+1] <= 1'b0;
			end else if (en) begin
				v_s1[k+1] <= v_s1[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				tag_s1[k+1]  <= tag_s1[k];
				rem_s1[k+1]  <= take ? 67'(69'(rem_s1[k]) - trial) : rem_s1[k];
				root_s1[k+1] <= take ? (root_s1[k] | (35'd1 << B)) : root_s1[k];
			end
		end
	end

	always_comb begin
		out_valid = v_s1[Steps];
		out_tag   = tag_s1[Steps];
		out_root  = (68'(rem_s1[Steps]) >= 68'(root_s1[Steps]) + 68'd1)
			? root_s1[Steps] + 35'd1 : root_s1[Steps];
	end
endmodule
`default_nettype wire

### rtl/psa_cordic.sv
`default_nettype none
// Pipelined CORDIC, rotation (sin/cos) or vectoring (atan) mode, one
// micro-rotation per stage.
module psa_cordic
	import psa_pkg::*;
#(
	parameter int STEPS = 18,
	parameter bit VECTOR = 1'b0,
	parameter int TAG_W = 8
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire logic                in_valid,
	input  wire logic signed [55:0]  in_x,
	input  wire logic signed [55:0]  in_y,
	input  wire logic signed [35:0]  in_z,
	input  wire logic [TAG_W-1:0]    in_tag,
	output logic                     out_valid,
	output logic signed [55:0]       out_x,
	output logic signed [55:0]       out_y,
	output logic signed [35:0]       out_z,
	output logic [TAG_W-1:0]         out_tag
);
	logic [STEPS:0]          v_s1;
	logic signed [55:0]      x_s1 [STEPS+1];
	logic signed [55:0]      y_s1 [STEPS+1];
	logic signed [35:0]      z_s1 [STEPS+1];
	logic [TAG_W-1:0]        t_s1 [STEPS+1];

	always_comb begin
		v_s1[0] = in_valid;
		x_s1[0] = in_x;
		y_s1[0] = in_y;
		z_s1[0] = in_z;
		t_s1[0] = in_tag;
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_it
		logic signed [55:0] xs, ys;
		logic               up;
		always_comb begin
			xs = x_s1[i] >>> i;
			ys = y_s1[i] >>> i;
			up = VECTOR ? (y_s1[i] > 0) : (z_s1[i] >= 0);
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s1[i+1] <= 1'b0;
			end else if (en) begin
				v_s1[i+1] <= v_s1[i];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				t_s1[i+1] <= t_s1[i];
				if (VECTOR) begin
					x_s1[i+1] <= up ? x_s1[i] + ys : x_s1[i] - ys;
					y_s1[i+1] <= up ? y_s1[i] - xs : y_s1[i] + xs;
					z_s1[i+1] <= up ? z_s1[i] + atan_q30(i) : z_s1[i] - atan_q30(i);
				end else begin
					x_s1[i+1] <= up ? x_s1[i] - ys : x_s1[i] + ys;
					y_s1[i+1] <= up ? y_s1[i] + xs : y_s1[i] - xs;
					z_s1[i+1] <= up ? z_s1[i] - atan_q30(i) : z_s1[i] + atan_q30(i);
				end
			end
		end
	end

	assign out_valid = v_s1[STEPS];
	assign out_x     = x_s1[STEPS];
	assign out_y     = y_s1[STEPS];
	assign out_z     = z_s1[STEPS];
	assign out_tag   = t_s1[STEPS];
endmodule
`default_nettype wire

### rtl/psa_divider.sv
`default_nettype none
// Pipelined restoring divider, one quotient bit per stage, saturating at 2^31.
module psa_divider
	import psa_pkg::*;
#(
	parameter int TAG_W = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               in_valid,
	input  wire logic [99:0]        in_num,
	input  wire logic [63:0]        in_den,
	input  wire logic [TAG_W-1:0]   in_tag,
	output logic                    out_valid,
	output logic [31:0]             out_quot,
	output logic [TAG_W-1:0]        out_tag
);
	logic [31:0]        v_s1;
	logic [99:0]        n_s1 [32];
	logic [63:0]        d_s1 [32];
	logic [31:0]        q_s1 [32];
	logic               sat_s1 [32];
	logic [TAG_W-1:0]   t_s1 [32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1[0] <= 1'b0;
		end else if (en) begin
			v_s1[0] <= in_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			n_s1[0]   <= in_num;
			d_s1[0]   <= in_den;
			q_s1[0]   <= '0;
			t_s1[0]   <= in_tag;
			sat_s1[0] <= in_num >= (100'(in_den) << 31);
		end
	end

	for (genvar k = 0; k < 31; k++) begin : g_bit
		localparam int B = 30 - k;
		logic [99:0] sh;
		logic        ge;
		always_comb begin
			sh = 100'(d_s1[k]) << B;
			ge = n_s1[k] >= sh;
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s1[k+1] <= 1'b0;
			end else if (en) begin
				v_s1[k+1] <= v_s1[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				d_s1[k+1]   <= d_s1[k];
				t_s1[k+1]   <= t_s1[k];
				sat_s1[k+1] <= sat_s1[k];
				n_s1[k+1]   <= ge ? n_s1[k] - sh : n_s1[k];
				q_s1[k+1]   <= ge ? (q_s1[k] | (32'd1 << B)) : q_s1[k];
			end
		end
	end

	assign out_valid = v_s1[31];
	assign out_quot  = sat_s1[31] ? 32'h8000_0000 : q_s1[31];
	assign out_tag   = t_s1[31];
endmodule
`default_nettype wire

### rtl/pursuit_steering_angle.sv
// pursuit_steering_angle: fixed-point pure-pursuit steering.
// Stages: input stage, sqrt 34 with the sin/cos CORDIC beside it, four glue stages,
// divider 32, radius stage, atan CORDIC, output register.
// Throughput: one item per cycle; the whole pipe advances when the output is free.
// Reset (arst_n low, asynchronous): all valid bits clear, wheelbase = 1.0 m,
// compensation on.
`default_nettype none
`include "pursuit_steering_angle_macros.svh"
module pursuit_steering_angle
	import psa_pkg::*;
#(
	parameter int FRAC_BITS    = 16,
	parameter int CORDIC_STEPS = 18
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [19:0] cfg_wdata,
	psa_stream_if.sink       in_ch,
	psa_stream_if.source     out_ch
);
	localparam logic [63:0] OneQ = 64'd1 << FRAC_BITS;

	logic [19:0] wheelbase_q;
	logic        comp_en_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wheelbase_q <= 20'(OneQ);
			comp_en_q   <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				RegWheelbase: wheelbase_q <= cfg_wdata;
				RegDistComp:  comp_en_q   <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// whole pipe moves together; output register frees when taken
	logic en;
	logic out_v_q;
	assign en          = !out_v_q || out_ch.ready;
	assign in_ch.ready = en;
	wire acc = in_ch.valid && in_ch.ready;

	// stage 1: offsets and reduced heading registered; squares formed after it
	logic               v_s1;
	logic signed [32:0] ex_s1, ey_s1;
	logic signed [35:0] z_s1;
	logic               neg_s1;
	logic signed [31:0] px, py, tx, ty;
	logic signed [19:0] hd;
	assign px = in_ch.data[31:0];
	assign py = in_ch.data[63:32];
	assign hd = in_ch.data[83:64];
	assign tx = in_ch.data[115:84];
	assign ty = in_ch.data[147:116];

	logic signed [35:0] za, zb;
	logic               nga;
	always_comb begin
		za  = 36'(hd) <<< (30 - FRAC_BITS);
		// |za| stays below two turns, so one subtract gives the truncated remainder
		zb  = za;
		if (za >= TwoPiQ30) zb = za - TwoPiQ30;
		else if (za <= -TwoPiQ30) zb = za + TwoPiQ30;
		if (zb > PiQ30) zb = zb - TwoPiQ30;
		if (zb < -PiQ30) zb = zb + TwoPiQ30;
		nga = 1'b0;
		if (zb > HalfPiQ30) begin
			zb = zb - PiQ30; nga = 1'b1;
		end else if (zb < -HalfPiQ30) begin
			zb = zb + PiQ30; nga = 1'b1;
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= acc;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			ex_s1  <= 33'(tx) - 33'(px);
			ey_s1  <= 33'(ty) - 33'(py);
			z_s1   <= zb;
			neg_s1 <= nga;
		end
	end

	logic [32:0] ax, ay;
	logic [65:0] sumsq;
	always_comb begin
		ax = ex_s1[32] ? 33'(-ex_s1) : 33'(ex_s1);
		ay = ey_s1[32] ? 33'(-ey_s1) : 33'(ey_s1);
		sumsq = 66'(ax) * 66'(ax) + 66'(ay) * 66'(ay);
	end

	// sqrt and sin/cos CORDIC run side by side; only the sqrt tag carries neg, ex, ey
	localparam int TagA = 67;
	logic               sq_v;
	logic [34:0]        d_root;
	logic [TagA-1:0]    sq_tag;
	psa_sqrt #(.TAG_W(TagA)) u_sqrt (
		.clk, .arst_n, .en, .in_valid(v_s1), .in_n(sumsq),
		.in_tag({neg_s1, ex_s1, ey_s1}),
		.out_valid(sq_v), .out_root(d_root), .out_tag(sq_tag)
	);

	logic                cs_v;
	logic signed [55:0]  cs_x, cs_y;
	logic signed [35:0]  cs_z;
	logic [0:0]          cs_tag;
	psa_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b0), .TAG_W(1)) u_sincos (
		.clk, .arst_n, .en, .in_valid(v_s1),
		.in_x(56'(InvGainQ30)), .in_y(56'sd0), .in_z(z_s1), .in_tag(1'b0),
		.out_valid(cs_v), .out_x(cs_x), .out_y(cs_y), .out_z(cs_z), .out_tag(cs_tag)
	);

	// align the CORDIC and sqrt outputs by delaying the shorter path
	localparam int SqLat = 34;
	localparam int Gap   = (SqLat > CORDIC_STEPS) ? SqLat - CORDIC_STEPS : 0;
	localparam int Gap2  = (CORDIC_STEPS > SqLat) ? CORDIC_STEPS - SqLat : 0;
	logic signed [55:0] cd_x [Gap+1];
	logic signed [55:0] cd_y [Gap+1];
	assign cd_x[0] = cs_x;
	assign cd_y[0] = cs_y;
	for (genvar g = 0; g < Gap; g++) begin : g_cdl
		always_ff @(posedge clk) begin
			if (en) begin
				cd_x[g+1] <= cd_x[g];
				cd_y[g+1] <= cd_y[g];
			end
		end
	end
	logic [TagA+34:0] sd [Gap2+1];
	logic             sdv [Gap2+1];
	assign sd[0]  = {sq_tag, d_root};
	assign sdv[0] = sq_v;
	for (genvar g = 0; g < Gap2; g++) begin : g_sdl
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sdv[g+1] <= 1'b0;
			else if (en) sdv[g+1] <= sdv[g];
		end
		always_ff @(posedge clk) begin
			if (en) sd[g+1] <= sd[g];
		end
	end

	// stage A: sin/cos to Q24, sign restored
	logic               va_s2;
	logic [34:0]        d_s2;
	logic signed [32:0] ex_s2, ey_s2;
	logic signed [55:0] c24_s2, s24_s2;
	logic               neg_a;
	logic signed [55:0] cx, sy;
	assign {neg_a, ex_s2, ey_s2, d_s2} = sd[Gap2];
	always_comb begin
		cx = neg_a ? -cd_x[Gap] : cd_x[Gap];
		sy = neg_a ? -cd_y[Gap] : cd_y[Gap];
	end
	logic signed [25:0] c24_a, s24_a;
	logic [34:0]        d_a;
	logic signed [32:0] exa, eya;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) va_s2 <= 1'b0;
		else if (en) va_s2 <= sdv[Gap2];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			c24_a <= 26'((cx + 56'sd32) >>> 6);
			s24_a <= 26'((sy + 56'sd32) >>> 6);
			d_a   <= d_s2;
			exa   <= ex_s2;
			eya   <= ey_s2;
		end
	end
	assign c24_s2 = 56'(c24_a);
	assign s24_s2 = 56'(s24_a);

	// stage B: two multiplies registered
	logic               vb_s3;
	logic signed [59:0] p1_s3, p2_s3;
	logic [34:0]        d_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vb_s3 <= 1'b0;
		else if (en) vb_s3 <= va_s2;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			p1_s3 <= 60'(exa) * 60'(s24_s2);
			p2_s3 <= 60'(eya) * 60'(c24_s2);
			d_s3  <= d_a;
		end
	end

	// stage C: dy, c factor, d^2
	logic               vc_s4;
	logic signed [36:0] dy_s4;
	logic [34:0]        d_s4;
	logic [19:0]        cq_s4;
	logic [69:0]        dd_s4;
	logic signed [60:0] dyf;
	logic [35:0]        dp2;
	logic [57:0]        div5;
	logic [34:0]        addv;
	logic               capped;
	always_comb begin
		dyf    = (61'(p1_s3) - 61'(p2_s3) + (61'sd1 <<< 23)) >>> 24;
		// (d+2)/5 only matters below the cap (20 in Q), where it fits 29 bits;
		// reciprocal multiply by ceil(2^31/5) is exact there
		dp2    = 36'(d_s3) + 36'd2;
		capped = 64'(dp2) >= 64'd20 * OneQ;
		div5   = 58'(dp2[28:0]) * 58'd429496730;
		addv   = 35'(div5 >> 31);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vc_s4 <= 1'b0;
		else if (en) vc_s4 <= vb_s3;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			dy_s4 <= 37'(dyf);
			d_s4  <= d_s3;
			dd_s4 <= 70'(d_s3) * 70'(d_s3);
			if (!comp_en_q) cq_s4 <= 20'(OneQ);
			else if (capped) cq_s4 <= 20'(64'd5 * OneQ);
			else cq_s4 <= 20'(OneQ + 64'(addv));
		end
	end

	// stage D: denominator, numerator
	logic               vd_s5;
	logic [63:0]        den_s5;
	logic [99:0]        num_s5;
	logic               str_s5, pos_s5;
	logic [34:0]        d_s5;
	logic [36:0]        ady;
	assign ady = dy_s4[36] ? 37'(-dy_s4) : 37'(dy_s4);
	logic [63:0] denw;
	assign denw = 64'(ady) * 64'(cq_s4);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vd_s5 <= 1'b0;
		else if (en) vd_s5 <= vc_s4;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			den_s5 <= (64'(ady) <= (OneQ / 64'd1000000)) ? 64'd1 : denw;
			num_s5 <= (100'(dd_s4) << (FRAC_BITS - 1)) + 100'(denw >> 1);
			str_s5 <= 64'(ady) <= (OneQ / 64'd1000000);
			pos_s5 <= dy_s4 > 0;
			d_s5   <= d_s4;
		end
	end

	logic        dv_v;
	logic [31:0] q;
	logic [36:0] dv_tag;
	psa_divider #(.TAG_W(37)) u_div (
		.clk, .arst_n, .en, .in_valid(vd_s5), .in_num(num_s5), .in_den(den_s5),
		.in_tag({str_s5, pos_s5, d_s5}),
		.out_valid(dv_v), .out_quot(q), .out_tag(dv_tag)
	);

	// stage E: radius
	logic               ve_s6;
	logic signed [32:0] rad_s6;
	logic               str_s6;
	logic [30:0]        dist_s6;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ve_s6 <= 1'b0;
		else if (en) ve_s6 <= dv_v;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			str_s6  <= dv_tag[36];
			dist_s6 <= (dv_tag[34:0] > 35'h7FFF_FFFF) ? 31'h7FFF_FFFF : dv_tag[30:0];
			if (dv_tag[36])
				rad_s6 <= (64'd9000 * OneQ > 64'h7FFF_FFFF) ? 33'sh7FFF_FFFF
					: 33'(64'd9000 * OneQ);
			else if (dv_tag[35]) rad_s6 <= -$signed({1'b0, q});
			else rad_s6 <= (q > 32'h7FFF_FFFF) ? 33'sh7FFF_FFFF : $signed({1'b0, q});
		end
	end

	logic [32:0] arad;
	assign arad = rad_s6[32] ? 33'(-rad_s6) : 33'(rad_s6);
	logic                at_v;
	logic signed [55:0]  at_x, at_y;
	logic signed [35:0]  at_z;
	logic [65:0]         at_tag;
	psa_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b1), .TAG_W(66)) u_atan (
		.clk, .arst_n, .en, .in_valid(ve_s6),
		.in_x($signed(56'(arad) << 20)), .in_y($signed(56'(wheelbase_q) << 20)),
		.in_z(36'sd0), .in_tag({str_s6, wheelbase_q == 20'd0, dist_s6, rad_s6}),
		.out_valid(at_v), .out_x(at_x), .out_y(at_y), .out_z(at_z), .out_tag(at_tag)
	);

	// output register
	logic signed [35:0] zc;
	logic signed [35:0] ang;
	logic signed [17:0] angs;
	always_comb begin
		zc = at_z;
		if (zc < 0) zc = '0;
		if (zc > HalfPiQ30) zc = HalfPiQ30;
		ang = (zc + (36'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
		if (at_tag[32]) ang = -ang;
		if (ang > 36'sd131071) ang = 36'sd131071;
		if (ang < -36'sd131072) ang = -36'sd131072;
		angs = (at_tag[65] || at_tag[64]) ? 18'sd0 : 18'(ang);
	end
	logic [81:0] out_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (en) out_v_q <= at_v;
	end
	always_ff @(posedge clk) begin
		if (en) out_q <= {at_tag[65], at_tag[31:0], at_tag[63:33], angs};
	end
	assign out_ch.valid = out_v_q;
	assign out_ch.data  = out_q;

	`PSA_ASSERT_NXT(a_hold, clk, arst_n, out_v_q && !out_ch.ready, out_v_q && $stable(out_q), "stalled result changed")
	`PSA_ASSERT_IMP(a_rdy, clk, arst_n, !out_v_q, in_ch.ready, "input blocked with empty output")
	`PSA_ASSERT_IMP(a_str, clk, arst_n, out_v_q && out_q[81], out_q[17:0] == 18'd0, "straight with nonzero angle")
endmodule
`default_nettype wire
